>>> src/atg_pkg.sv
// ----------------------------------------------------------------------------
// atg_pkg: shared types, constants and functions for the tilt and yaw block
// Holds the CORDIC vector word, the arctangent table and the fixed-point
// limits used by the cells, the chain and the top level.
// ----------------------------------------------------------------------------
package atg_pkg;

	// Width of the CORDIC x and y words and of the angle word (Q.16 degrees).
	localparam int XW = 36;
	localparam int ZW = 26;

	// Configuration register indexes.
	localparam logic [7:0] REG_GYRO_SCALE = 8'd0;
	localparam logic [7:0] REG_DEADBAND   = 8'd1;

	localparam logic [23:0] GYRO_SCALE_RST = 24'd128000;
	localparam logic [30:0] DEADBAND_RST   = 31'd13107;

	localparam logic signed [ZW-1:0] HALF_TURN = ZW'(11796480);
	// CORDIC gain in Q2.30, applied to ay so that it matches the magnitude.
	localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;
	localparam logic signed [47:0] YAW_LIMIT = 48'sd140733193388032;

	localparam logic signed [18:0] PITCH_LIM = 19'sd46080;
	localparam logic signed [18:0] ROLL_LIM  = 19'sd23040;

	// Rounded arctangent of 2^-i in Q.16 degrees.
	localparam logic signed [ZW-1:0] ATAN_TAB [24] = '{
		ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945), ZW'(234379),
		ZW'(117304), ZW'(58666), ZW'(29335), ZW'(14668), ZW'(7334),
		ZW'(3667), ZW'(1833), ZW'(917), ZW'(458), ZW'(229), ZW'(115),
		ZW'(57), ZW'(29), ZW'(14), ZW'(7), ZW'(4), ZW'(2), ZW'(1), ZW'(0)
	};

	// One vector travelling along the chain of cells.
	typedef struct packed {
		logic                 zero;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} vec_t;

	// Brings a vector into the right half plane before the iterations.
	function automatic vec_t cordic_prep(input logic signed [XW-1:0] y,
		input logic signed [XW-1:0] x);
		vec_t v;
		v.zero = (x == '0) && (y == '0);
		v.x = x;
		v.y = y;
		v.z = '0;
		if (x[XW-1]) begin
			v.z = y[XW-1] ? -HALF_TURN : HALF_TURN;
			v.x = -x;
			v.y = -y;
		end
		return v;
	endfunction

	// Negates an angle, rounds it to 1/256 degree and clamps it.
	function automatic logic signed [18:0] angle_256(input logic signed [ZW-1:0] z,
		input logic signed [18:0] lim);
		logic signed [ZW:0] t;
		logic signed [18:0] a;
		t = -{z[ZW-1], z} + (ZW+1)'(128);
		a = 19'(t >>> 8);
		if (a > lim)
			a = lim;
		else if (a < -lim)
			a = -lim;
		return a;
	endfunction

endpackage

>>> src/atg_cordic_cell.sv
// ----------------------------------------------------------------------------
// atg_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates the incoming vector by the fixed angle of its position in the
// row and registers the result for the next cell.
// ----------------------------------------------------------------------------
module atg_cordic_cell import atg_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  vec_t in_vec,
	output logic out_valid,
	output vec_t out_vec
);

	logic signed [XW-1:0] dx, dy;
	vec_t nxt;

	// Rotate towards the x axis, sign of y decides the direction.
	always_comb begin
		dx = in_vec.y >>> SHIFT;
		dy = in_vec.x >>> SHIFT;
		nxt = in_vec;
		if (!in_vec.y[XW-1]) begin
			nxt.x = in_vec.x + dx;
			nxt.y = in_vec.y - dy;
			nxt.z = in_vec.z + ATAN_TAB[SHIFT];
		end else begin
			nxt.x = in_vec.x - dx;
			nxt.y = in_vec.y + dy;
			nxt.z = in_vec.z - ATAN_TAB[SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_vec <= nxt;
	end

endmodule

>>> src/atg_cordic_chain.sv
// ----------------------------------------------------------------------------
// atg_cordic_chain: row of CORDIC cells
// A vector enters, passes the STEPS registered cells and leaves with its angle
// and gain-scaled magnitude; a zero vector leaves as angle and magnitude 0.
// ----------------------------------------------------------------------------
module atg_cordic_chain import atg_pkg::*; #(
	parameter int STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  vec_t                 in_vec,
	output logic                 out_valid,
	output logic signed [XW-1:0] out_mag,
	output logic signed [ZW-1:0] out_angle
);

	logic valid_c [STEPS+1];
	vec_t vec_c   [STEPS+1];

	assign valid_c[0] = in_valid;
	assign vec_c[0]   = in_vec;

	// One cell per iteration, each with its own shift and table angle.
	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		atg_cordic_cell #(.SHIFT(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_c[i]),
			.in_vec   (vec_c[i]),
			.out_valid(valid_c[i+1]),
			.out_vec  (vec_c[i+1])
		);
	end

	// The zero vector is marked, iterated as well, and its outputs forced to 0.
	assign out_valid = valid_c[STEPS];
	assign out_mag   = vec_c[STEPS].zero ? '0 : vec_c[STEPS].x;
	assign out_angle = vec_c[STEPS].zero ? '0 : vec_c[STEPS].z;

endmodule

>>> src/accel_tilt_and_gyro_yaw_top.sv
// ----------------------------------------------------------------------------
// accel_tilt_and_gyro_yaw_top: tilt from accelerometer and integrated yaw
// Computes pitch and roll by CORDIC vectoring and integrates the gyro rate.
// ----------------------------------------------------------------------------
// Usage:
// Each input word on the s_ channel is one tick. tuser is the sample flag;
// when set, the raw accel and gyro counts are latched, otherwise the held
// counts are used. Every input word yields exactly one output word on m_.
// Pitch and roll pass one after the other through a row of CORDIC_STEPS
// cells, after the accept and multiply steps and before the output step,
// and a new word is taken only once the previous one has been loaded into
// the output register. The yaw rate, its multiply and the accumulator
// update run beside the pitch pass. The output register holds a finished
// word while the receiver stalls; the next input word may then be accepted
// and worked on, and it waits at the end until the register frees.
// Reset clears the held counts and the yaw accumulator and sets the registers
// gyro_scale (128000) and rate_deadband (13107). The configuration port
// is always ready; writes to an unknown index are ignored.
// ----------------------------------------------------------------------------
module accel_tilt_and_gyro_yaw_top import atg_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// accel_x[15:0], accel_y[31:16], accel_z[47:32], gyro_z[63:48], delta_t[87:64]
	input  logic [87:0]  s_tdata,
	// sample_valid[0]
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pitch_angle[16:0], roll_angle[32:17], yaw_angle[64:33], yaw_rate[96:65], zeros
	output logic [103:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_PITCH, S_ROLL, S_OUT} state_t;

	state_t state_q;
	logic [23:0] gyro_scale_q;
	logic [30:0] deadband_q;
	logic signed [15:0] ax_q, ay_q, az_q, gz_q;
	logic [23:0] dt_q;
	logic signed [47:0] acc_q;
	logic signed [40:0] rprod_q;
	logic signed [47:0] yk_prod_q;
	logic signed [31:0] rate_q;
	logic signed [56:0] yprod_q;
	logic [1:0] ph_q;
	logic signed [16:0] pitch_q;
	logic signed [15:0] roll_q;

	logic chain_in_valid, chain_out_valid;
	vec_t chain_in;
	logic signed [XW-1:0] chain_mag;
	logic signed [ZW-1:0] chain_angle;

	logic signed [32:0] rate_full;
	logic signed [31:0] rate_db;
	logic [31:0] rate_abs;
	logic signed [48:0] inc;
	logic signed [49:0] acc_sum;
	logic signed [XW-1:0] p_x, p_y, r_y;
	logic signed [18:0] pitch_a, roll_a;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_scale_q <= GYRO_SCALE_RST;
			deadband_q   <= DEADBAND_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_GYRO_SCALE)
				gyro_scale_q <= cfg_data[23:0];
			else if (cfg_index == REG_DEADBAND)
				deadband_q <= cfg_data[30:0];
		end
	end

	// Rate rounding, deadband and yaw increment.
	always_comb begin
		rate_full = 33'((rprod_q + 41'sd128) >>> 8);
		rate_db   = rate_full[31:0];
		rate_abs  = rate_db[31] ? 32'(-rate_db) : 32'(rate_db);
		if (rate_abs < {1'b0, deadband_q})
			rate_db = '0;
		inc = 49'((yprod_q + 57'sd128) >>> 8);
		acc_sum = 50'(acc_q) + 50'(inc);
	end

	// Vectors entering the cell row: pitch first, then roll.
	always_comb begin
		p_x = XW'({{(XW-16){az_q[15]}}, az_q}) <<< 14;
		p_y = -(XW'({{(XW-16){ax_q[15]}}, ax_q}) <<< 14);
		r_y = XW'(yk_prod_q >>> 16);
		chain_in_valid = (state_q == S_MUL) || (state_q == S_PITCH && chain_out_valid);
		if (state_q == S_MUL)
			chain_in = cordic_prep(p_y, p_x);
		else
			chain_in = cordic_prep(r_y, chain_mag);
		pitch_a = angle_256(chain_angle, PITCH_LIM);
		roll_a  = angle_256(chain_angle, ROLL_LIM);
	end

	atg_cordic_chain #(.STEPS(CORDIC_STEPS)) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_in_valid),
		.in_vec   (chain_in),
		.out_valid(chain_out_valid),
		.out_mag  (chain_mag),
		.out_angle(chain_angle)
	);

	// Sequencer with held counts, yaw accumulator and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ax_q     <= '0;
			ay_q     <= '0;
			az_q     <= '0;
			gz_q     <= '0;
			acc_q    <= '0;
			ph_q     <= '0;
			m_tvalid <= 1'b0;
		end else begin
			// The output step reloads the register itself.
			if (m_tvalid && m_tready && state_q != S_OUT)
				m_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser) begin
							ax_q <= s_tdata[15:0];
							ay_q <= s_tdata[31:16];
							az_q <= s_tdata[47:32];
							gz_q <= s_tdata[63:48];
						end
						dt_q    <= s_tdata[87:64];
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					rprod_q   <= 41'(gz_q) * $signed({1'b0, gyro_scale_q});
					yk_prod_q <= 48'(ay_q) * 48'(GAIN_Q30);
					ph_q      <= '0;
					state_q   <= S_PITCH;
				end
				S_PITCH: begin
					if (ph_q != 2'd3)
						ph_q <= ph_q + 2'd1;
					unique case (ph_q)
						2'd0: rate_q <= rate_db;
						2'd1: yprod_q <= 57'(rate_q) * $signed({1'b0, dt_q});
						2'd2: begin
							if (acc_sum > 50'(YAW_LIMIT))
								acc_q <= YAW_LIMIT;
							else if (acc_sum < -50'(YAW_LIMIT))
								acc_q <= -YAW_LIMIT;
							else
								acc_q <= acc_sum[47:0];
						end
						default: ;
					endcase
					if (chain_out_valid) begin
						pitch_q <= pitch_a[16:0];
						state_q <= S_ROLL;
					end
				end
				S_ROLL: begin
					if (chain_out_valid) begin
						roll_q  <= roll_a[15:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tdata  <= {7'd0, rate_q, acc_q[47:16], roll_q, pitch_q};
						m_tvalid <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The cell row only delivers during the two vectoring passes.
	a_chain_phase: assert property (@(posedge clk) disable iff (!arst_n)
		chain_out_valid |-> (state_q == S_PITCH || state_q == S_ROLL))
		else $error("cell row output outside a vectoring pass");

	// Yaw accumulator stays inside its saturation limits.
	a_yaw_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q <= YAW_LIMIT) && (acc_q >= -YAW_LIMIT))
		else $error("yaw accumulator beyond limit");

	// An accepted word starts the multiply step.
	a_accept_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_MUL))
		else $error("accepted word did not start");

endmodule

>>> test/accel_tilt_and_gyro_yaw_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accel_tilt_and_gyro_yaw_checker: predicts and checks tilt and yaw words
// Watches the input, output and configuration channels of the block, keeps
// its own copy of the held counts, the yaw accumulator and the registers,
// and compares each output word with the oldest predicted one.
// ----------------------------------------------------------------------------
module accel_tilt_and_gyro_yaw_checker import atg_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [87:0]  s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [103:0] m_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           fail_count,
	output int           pending_words
);

	typedef struct packed {
		logic signed [31:0] rate;
		logic signed [31:0] yaw;
		logic signed [15:0] roll;
		logic signed [16:0] pitch;
	} attitude_t;

	localparam longint HALF_TURN_DEG = 64'sd11796480;
	localparam longint ATAN_DEG [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0
	};

	logic [23:0] scale_q;
	logic [30:0] deadband_q;
	logic signed [15:0] held_ax, held_ay, held_az, held_gz;
	longint yaw_acc;
	attitude_t expected_words [$];
	int mismatch_count;

	assign fail_count = mismatch_count;
	assign pending_words = expected_words.size();

	// Vectoring of (x, y); returns the angle and the gain-scaled magnitude.
	function automatic longint vector_angle(input longint y_in, input longint x_in,
		output longint magnitude);
		longint x, y, z, dx, dy;
		x = x_in;
		y = y_in;
		z = 0;
		if (x == 0 && y == 0) begin
			magnitude = 0;
			return 0;
		end
		if (x < 0) begin
			z = (y >= 0) ? HALF_TURN_DEG : -HALF_TURN_DEG;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += ATAN_DEG[i];
			end else begin
				x -= dx;
				y += dy;
				z -= ATAN_DEG[i];
			end
		end
		magnitude = x;
		return z;
	endfunction

	function automatic longint to_256th_clamped(input longint z, input longint lim);
		longint a;
		a = (-z + 128) >>> 8;
		return a > lim ? lim : (a < -lim ? -lim : a);
	endfunction

	// Works out the output word of one tick and advances the yaw state.
	function automatic attitude_t predict_attitude(input logic [87:0] d, input logic smp);
		attitude_t w;
		longint rate, mag, unused, zp, zr, yk;
		if (smp) begin
			held_ax = d[15:0];
			held_ay = d[31:16];
			held_az = d[47:32];
			held_gz = d[63:48];
		end
		rate = (longint'(held_gz) * longint'(scale_q) + 128) >>> 8;
		if ((rate < 0 ? -rate : rate) < longint'(deadband_q))
			rate = 0;
		yaw_acc += (rate * longint'(d[87:64]) + 128) >>> 8;
		if (yaw_acc > 64'sd140733193388032)
			yaw_acc = 64'sd140733193388032;
		else if (yaw_acc < -64'sd140733193388032)
			yaw_acc = -64'sd140733193388032;
		zp = vector_angle(-longint'(held_ax) * 16384, longint'(held_az) * 16384, mag);
		yk = (longint'(held_ay) * 16384 * 64'sd1768195363) >>> 30;
		zr = vector_angle(yk, mag, unused);
		w.pitch = 17'(to_256th_clamped(zp, 46080));
		w.roll = 16'(to_256th_clamped(zr, 23040));
		w.yaw = 32'(yaw_acc >>> 16);
		w.rate = 32'(rate);
		return w;
	endfunction

	// Register writes, accepted input words and output words, all at the edge.
	always @(posedge clk or negedge arst_n) begin
		attitude_t got, want;
		if (!arst_n) begin
			scale_q <= GYRO_SCALE_RST;
			deadband_q <= DEADBAND_RST;
			held_ax = '0;
			held_ay = '0;
			held_az = '0;
			held_gz = '0;
			yaw_acc = 0;
			mismatch_count <= 0;
			expected_words.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_GYRO_SCALE)
					scale_q <= cfg_data[23:0];
				else if (cfg_index == REG_DEADBAND)
					deadband_q <= cfg_data[30:0];
			end
			if (s_tvalid && s_tready)
				expected_words.push_back(predict_attitude(s_tdata, s_tuser));
			if (m_tvalid && m_tready) begin
				got = m_tdata[96:0];
				if (expected_words.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected output word %h", got);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_words.pop_front();
					if (got !== want || m_tdata[103:97] !== '0) begin
						if (mismatch_count < 10)
							$display("mismatch: pitch %0d/%0d roll %0d/%0d yaw %0d/%0d rate %0d/%0d (exp/act)",
								want.pitch, got.pitch, want.roll, got.roll,
								want.yaw, got.yaw, want.rate, got.rate);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
		end
	end

endmodule

>>> test/accel_tilt_and_gyro_yaw_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accel_tilt_and_gyro_yaw_top_test: stimulus and verdict for the tilt block
// Drives directed and random ticks with random idling on both sides, walks
// the registers through several settings and leaves checking to the checker.
// ----------------------------------------------------------------------------
module accel_tilt_and_gyro_yaw_top_test;
	import atg_pkg::*;

	localparam int LATENCY = 2 * 16 + 3;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser;
	logic [87:0] s_tdata;
	logic m_tvalid, m_tready;
	logic [103:0] m_tdata;
	logic cfg_valid, cfg_ready;
	logic [7:0] cfg_index;
	logic [31:0] cfg_data;
	int fail_count, pending_words;
	int idle_cycles;
	bit sink_quiet, long_hold;

	accel_tilt_and_gyro_yaw_top u_top (.*);

	accel_tilt_and_gyro_yaw_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: random bursts of stall, one long hold-off, none at the end.
	initial begin
		int hold;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				m_tready <= 1'b1;
				long_hold = 1'b0;
			end else if (!sink_quiet && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 15);
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
				m_tready <= 1'b1;
			end else
				m_tready <= 1'b1;
		end
	end

	// Watchdog on cycles without any accepted word.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// Leaves tvalid high after acceptance; the next tick reloads the word, a gap or a register write drops it.
	task automatic send_tick(input logic smp, input logic [15:0] ax, input logic [15:0] ay,
		input logic [15:0] az, input logic [15:0] gz, input logic [23:0] dt, input bit gaps);
		int gap;
		if (gaps && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 15);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= smp;
		s_tdata <= {dt, gz, az, ay, ax};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic write_register(input logic [7:0] idx, input logic [31:0] value);
		s_tvalid <= 1'b0;
		while (pending_words != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_count();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_ticks(input int count, input bit gaps);
		logic [23:0] dt;
		for (int i = 0; i < count; i++) begin
			dt = ($urandom_range(0, 9) == 0) ? 24'hFFFFFF : 24'($urandom_range(0, 1 << 20));
			send_tick($urandom_range(0, 3) != 0, pick_count(), pick_count(), pick_count(),
				pick_count(), dt, gaps);
		end
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sink_quiet = 1'b0;
		long_hold = 1'b0;
		idle_cycles = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero vector, negative x with both signs of y, extremes, hold without sample.
		send_tick(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'd1000, 1'b0);
		send_tick(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'd0, 1'b0);
		send_tick(1'b1, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 24'hFFFFFF, 1'b0);
		send_tick(1'b1, 16'h0001, 16'h0000, 16'h8000, 16'h8000, 24'hFFFFFF, 1'b0);
		send_tick(1'b1, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 24'd12345, 1'b0);
		send_tick(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 24'd1, 1'b0);
		send_tick(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 24'hFFFFFF, 1'b0);
		send_tick(1'b1, 16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF, 24'h800000, 1'b0);
		send_tick(1'b1, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 24'd0, 1'b0);
		send_tick(1'b1, 16'h8000, 16'h0000, 16'h0000, 16'h0001, 24'd77, 1'b0);
		send_tick(1'b0, 16'h1234, 16'h5678, 16'h1111, 16'h2222, 24'd5, 1'b0);

		// Full scale with no deadband drives yaw to saturation both ways.
		write_register(REG_GYRO_SCALE, 32'hFFFFFFFF);
		write_register(REG_DEADBAND, 32'd0);
		send_tick(1'b1, 16'h0100, 16'h0100, 16'h4000, 16'h7FFF, 24'hFFFFFF, 1'b0);
		repeat (6) send_tick(1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 24'hFFFFFF, 1'b0);
		send_tick(1'b1, 16'h0100, 16'h0100, 16'h4000, 16'h8000, 24'hFFFFFF, 1'b0);
		repeat (12) send_tick(1'b0, 16'h0, 16'h0, 16'h0, 16'h0, 24'hFFFFFF, 1'b0);
		write_register(8'd7, 32'h12345678);

		// Random phases over several register settings.
		random_ticks(120, 1'b1);
		write_register(REG_GYRO_SCALE, 32'd0);
		write_register(REG_DEADBAND, 32'hFFFFFFFF);
		random_ticks(60, 1'b1);
		write_register(REG_GYRO_SCALE, $urandom);
		write_register(REG_DEADBAND, $urandom_range(0, 1 << 20));
		long_hold = 1'b1;
		random_ticks(120, 1'b1);
		write_register(REG_GYRO_SCALE, 32'd128000);
		write_register(REG_DEADBAND, 32'd13107);
		random_ticks(120, 1'b1);
		sink_quiet = 1'b1;
		random_ticks(80, 1'b0);
		s_tvalid <= 1'b0;

		while (pending_words != 0)
			@(posedge clk);
		repeat (LATENCY * 2) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
